[sv/cosine_best_match_search_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the cosine best match search block
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COSINE_BEST_MATCH_SEARCH_ASSERT_SVH
`define COSINE_BEST_MATCH_SEARCH_ASSERT_SVH

// same-cycle implication
`define CBMS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define CBMS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[sv/cbms_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbms_pkg
// Widths and interface types shared by the search top level and score engine.
// ---------------------------------------------------------------------------
package cbms_pkg;

    localparam int MAX_DIM    = 512;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int ADDR_W     = $clog2(MAX_DIM);
    localparam int CFG_W      = 10;
    localparam int INDEX_BITS = 24;
    localparam int ELEM_W     = 16;
    localparam int NORM_W     = 40;
    localparam int DOT_W      = 42;
    localparam int SCORE_W    = 16;

    localparam logic [CFG_W-1:0] DIM_RESET = 10'd384;

    // op field codes
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // squared Q15 scale: 2^30
    localparam int FRAC_W  = 2 * (SCORE_W - 1);
    localparam int MUL_W   = DOT_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int P_W     = 2 * NORM_W;
    localparam int REM_W   = PROD_W + FRAC_W;
    localparam int DIV_W   = P_W + FRAC_W;
    localparam int QUO_W   = FRAC_W;
    localparam int ROOT_W  = SCORE_W - 1;
    localparam int CNT_W   = $clog2(MUL_W);

    typedef struct packed {
        logic                     start;
        logic signed [DOT_W-1:0]  dot;
        logic [NORM_W-1:0]        q_norm;
        logic [NORM_W-1:0]        d_norm;
    } score_req_t;

    typedef struct packed {
        logic                       busy;
        logic                       done;
        logic signed [SCORE_W-1:0]  score;
    } score_rsp_t;

endpackage

[sv/cbms_score.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbms_score
// Cosine score engine: trunc(32768*dot/sqrt(nq*nd)) clamped to Q1.15, built
// from a shift-add multiplier, a restoring divider and a bitwise square root.
// ---------------------------------------------------------------------------
module cbms_score (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cbms_pkg::score_req_t   req,
    output cbms_pkg::score_rsp_t   rsp
);
    import cbms_pkg::*;

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_MULP = 3'd1;
    localparam logic [2:0] E_MULR = 3'd2;
    localparam logic [2:0] E_DIV  = 3'd3;
    localparam logic [2:0] E_SQRT = 3'd4;
    localparam logic [2:0] E_DONE = 3'd5;

    localparam int SH_W = $clog2(ROOT_W);

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [MUL_W-1:0]        mul_a_reg, mul_a_next;
    logic [MUL_W-1:0]        mul_b_reg, mul_b_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [P_W-1:0]          p_reg, p_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]        d_reg, d_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic [ROOT_W-1:0]       k_reg, k_next;
    logic                    neg_reg, neg_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;

    logic [PROD_W-1:0]       mac;
    logic [MUL_W-1:0]        mag;
    logic                    ge;
    logic [REM_W-1:0]        rem_sub;
    logic [ROOT_W-1:0]       trial;
    logic [2*ROOT_W-1:0]     trial_sq;

    function automatic logic [SCORE_W-1:0] make_score(input logic sat,
                                                       input logic [ROOT_W-1:0] k,
                                                       input logic neg);
        logic [SCORE_W-1:0] m;
        m = sat ? {1'b1, {ROOT_W{1'b0}}} : {1'b0, k};
        if (neg)
            return ~m + 1'b1;
        else if (sat)
            return {1'b0, {ROOT_W{1'b1}}};
        else
            return m;
    endfunction

    // one shift-add step, multiplier bits MSB first
    assign mac = {acc_reg[PROD_W-2:0], 1'b0}
               + (mul_b_reg[MUL_W-1] ? PROD_W'(mul_a_reg) : {PROD_W{1'b0}});
    assign mag = req.dot[DOT_W-1] ? MUL_W'(-req.dot) : MUL_W'(req.dot);

    assign ge       = rem_reg >= REM_W'(d_reg);
    assign rem_sub  = rem_reg - REM_W'(d_reg);
    assign trial    = k_reg | (ROOT_W'(1) << cnt_reg[SH_W-1:0]);
    assign trial_sq = trial * trial;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        rem_next   = rem_reg;
        d_next     = d_reg;
        quo_next   = quo_reg;
        k_next     = k_reg;
        neg_next   = neg_reg;
        score_next = score_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    mul_a_next = MUL_W'(req.q_norm);
                    mul_b_next = MUL_W'(req.d_norm);
                    acc_next   = '0;
                    cnt_next   = CNT_W'(MUL_W - 1);
                    neg_next   = req.dot[DOT_W-1];
                    // magnitude is parked in rem until the norm product is done
                    rem_next   = REM_W'(mag);
                    state_next = E_MULP;
                end
            end
            E_MULP:
            begin
                acc_next   = mac;
                mul_b_next = {mul_b_reg[MUL_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    p_next     = mac[P_W-1:0];
                    mul_a_next = rem_reg[MUL_W-1:0];
                    mul_b_next = rem_reg[MUL_W-1:0];
                    acc_next   = '0;
                    cnt_next   = CNT_W'(MUL_W - 1);
                    state_next = E_MULR;
                end
            end
            E_MULR:
            begin
                acc_next   = mac;
                mul_b_next = {mul_b_reg[MUL_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rem_next   = {mac, {FRAC_W{1'b0}}};
                    d_next     = {p_reg, {FRAC_W{1'b0}}};
                    quo_next   = '0;
                    cnt_next   = CNT_W'(QUO_W);
                    state_next = E_DIV;
                end
            end
            E_DIV:
            begin
                d_next   = {1'b0, d_reg[DIV_W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(QUO_W))
                begin
                    // quotient reaches 2^30: root saturates at full scale
                    if (ge)
                    begin
                        score_next = make_score(1'b1, '0, neg_reg);
                        state_next = E_DONE;
                    end
                end
                else
                begin
                    if (ge)
                        rem_next = rem_sub;
                    quo_next = {quo_reg[QUO_W-2:0], ge};
                    if (cnt_reg == '0)
                    begin
                        k_next     = '0;
                        cnt_next   = CNT_W'(ROOT_W - 1);
                        state_next = E_SQRT;
                    end
                end
            end
            E_SQRT:
            begin
                if (trial_sq <= quo_reg)
                    k_next = trial;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    score_next = make_score(1'b0, k_next, neg_reg);
                    state_next = E_DONE;
                end
            end
            E_DONE:
            begin
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        acc_reg   <= acc_next;
        p_reg     <= p_next;
        rem_reg   <= rem_next;
        d_reg     <= d_next;
        quo_reg   <= quo_next;
        k_reg     <= k_next;
        neg_reg   <= neg_next;
        score_reg <= score_next;
    end

    assign rsp.busy  = (state_reg != E_IDLE);
    assign rsp.done  = (state_reg == E_DONE);
    assign rsp.score = score_reg;

endmodule

[sv/cosine_best_match_search.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cosine_best_match_search
// Brute-force cosine similarity nearest neighbor search over Q1.15 vectors.
// ---------------------------------------------------------------------------
// Each word is accepted (query store write or read), passes the element
// multipliers in S_MUL and is accumulated in S_ACC. The last element of a database
// vector adds the score engine: a shift-add multiply for the norm product,
// another for the squared dot, a 31-step restoring divide (1 step when the
// ratio saturates) and a 15-step square root; a zero-norm vector skips the
// engine. The result sits in an output register, so the next word is
// taken while it waits. Query element 0 restarts the search and clears the
// running best. dim_in_use (cfg_wr_en/cfg_wr_data) resets to 384; 0 acts as
// 1 and values above 512 act as 512.
// ---------------------------------------------------------------------------
`include "cosine_best_match_search_assert.svh"

module cosine_best_match_search (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [cbms_pkg::CFG_W-1:0]             cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   op,
    input  logic signed [cbms_pkg::ELEM_W-1:0]     element_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [cbms_pkg::INDEX_BITS-1:0]        vector_index,
    output logic signed [cbms_pkg::SCORE_W-1:0]    score,
    output logic                                   zero_norm,
    output logic [cbms_pkg::INDEX_BITS-1:0]        best_match_index,
    output logic signed [cbms_pkg::SCORE_W-1:0]    best_score,
    output logic                                   best_found
);
    import cbms_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SCORE = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;

    localparam int SQ_W = 2 * ELEM_W;

    logic [2:0]                state_reg;
    logic [CFG_W-1:0]          dim_reg;
    logic [ADDR_W-1:0]         fill_pos_reg;
    logic [ADDR_W-1:0]         elem_pos_reg;
    logic [NORM_W-1:0]         qnorm_reg;
    logic [NORM_W-1:0]         dnorm_reg;
    logic signed [DOT_W-1:0]   dot_reg;
    logic [INDEX_BITS-1:0]     vcount_reg;
    logic signed [SCORE_W-1:0] best_score_reg;
    logic [INDEX_BITS-1:0]     best_match_index_reg;
    logic                      best_found_reg;
    logic                      op_reg;
    logic                      last_reg;
    logic                      zero_reg;
    logic signed [ELEM_W-1:0]  v_reg;
    logic signed [ELEM_W-1:0]  q_rd_reg;
    logic signed [SQ_W-1:0]    prod_reg;
    logic [SQ_W-1:0]           sq_reg;

    logic                      out_valid_reg;
    logic [INDEX_BITS-1:0]     vector_index_reg;
    logic signed [SCORE_W-1:0] score_out_reg;
    logic                      zero_norm_reg;
    logic [INDEX_BITS-1:0]     best_match_index_out_reg;
    logic signed [SCORE_W-1:0] best_score_out_reg;
    logic                      best_found_out_reg;

    logic signed [ELEM_W-1:0]  qmem [MAX_DIM];

    logic [DIM_W-1:0]          eff_dim;
    logic [ADDR_W-1:0]         fill_pos, elem_pos, acc_addr;
    logic                      fill_last, elem_last;
    logic                      accept, q_wr, d_rd, restart;
    logic                      res_load, best_take;
    logic                      norm_zero;
    logic signed [SCORE_W-1:0] res_score;

    score_req_t                score_req;
    score_rsp_t                score_rsp;

    always_comb
    begin
        if (dim_reg == '0)
            eff_dim = DIM_W'(1);
        else if (dim_reg > CFG_W'(MAX_DIM))
            eff_dim = DIM_W'(MAX_DIM);
        else
            eff_dim = DIM_W'(dim_reg);
    end

    // a stored position past a lowered dimension wraps to 0
    assign fill_pos  = (DIM_W'(fill_pos_reg) >= eff_dim) ? '0 : fill_pos_reg;
    assign elem_pos  = (DIM_W'(elem_pos_reg) >= eff_dim) ? '0 : elem_pos_reg;
    assign fill_last = (DIM_W'(fill_pos) + 1'b1) >= eff_dim;
    assign elem_last = (DIM_W'(elem_pos) + 1'b1) >= eff_dim;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign q_wr     = accept && (op == OP_QUERY);
    assign d_rd     = accept && (op == OP_DATA);
    assign restart  = q_wr && (fill_pos == '0);
    assign acc_addr = (op == OP_DATA) ? elem_pos : fill_pos;

    assign norm_zero = (qnorm_reg == '0) || (dnorm_reg == '0);

    assign res_score = zero_reg ? '0 : score_rsp.score;
    assign best_take = !zero_reg && (res_score > best_score_reg);
    assign res_load  = (state_reg == S_RES) && (!out_valid_reg || out_ready);

    assign score_req.start  = (state_reg == S_CHK) && !norm_zero;
    assign score_req.dot    = dot_reg;
    assign score_req.q_norm = qnorm_reg;
    assign score_req.d_norm = dnorm_reg;

    cbms_score u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (score_req),
        .rsp   (score_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (q_wr)
            qmem[acc_addr] <= element_value;
        if (d_rd)
            q_rd_reg <= qmem[acc_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg    <= element_value;
            op_reg   <= op;
            last_reg <= elem_last;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= q_rd_reg * v_reg;
            sq_reg   <= SQ_W'(v_reg * v_reg);
        end
        if (state_reg == S_CHK)
            zero_reg <= norm_zero;
        if (res_load)
        begin
            vector_index_reg         <= vcount_reg;
            score_out_reg            <= res_score;
            zero_norm_reg            <= zero_reg;
            best_match_index_out_reg <= best_take ? vcount_reg : best_match_index_reg;
            best_score_out_reg       <= best_take ? res_score : best_score_reg;
            best_found_out_reg       <= best_take || best_found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            dim_reg              <= DIM_RESET;
            fill_pos_reg         <= '0;
            elem_pos_reg         <= '0;
            qnorm_reg            <= '0;
            dnorm_reg            <= '0;
            dot_reg              <= '0;
            vcount_reg           <= '0;
            best_score_reg       <= '0;
            best_match_index_reg <= '0;
            best_found_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                dim_reg <= cfg_wr_data;

            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (op == OP_DATA)
                            elem_pos_reg <= elem_last ? '0 : elem_pos + 1'b1;
                        else
                            fill_pos_reg <= fill_last ? '0 : fill_pos + 1'b1;
                        if (restart)
                        begin
                            qnorm_reg            <= '0;
                            elem_pos_reg         <= '0;
                            dot_reg              <= '0;
                            dnorm_reg            <= '0;
                            vcount_reg           <= '0;
                            best_score_reg       <= '0;
                            best_match_index_reg <= '0;
                            best_found_reg       <= 1'b0;
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (op_reg == OP_DATA)
                    begin
                        dot_reg   <= dot_reg + DOT_W'(prod_reg);
                        dnorm_reg <= dnorm_reg + NORM_W'(sq_reg);
                        state_reg <= last_reg ? S_CHK : S_IDLE;
                    end
                    else
                    begin
                        qnorm_reg <= qnorm_reg + NORM_W'(sq_reg);
                        state_reg <= S_IDLE;
                    end
                end
                S_CHK:
                begin
                    state_reg <= norm_zero ? S_RES : S_SCORE;
                end
                S_SCORE:
                begin
                    if (score_rsp.done)
                        state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (res_load)
                    begin
                        if (best_take)
                        begin
                            best_score_reg       <= res_score;
                            best_match_index_reg <= vcount_reg;
                            best_found_reg       <= 1'b1;
                        end
                        vcount_reg <= vcount_reg + 1'b1;
                        dot_reg    <= '0;
                        dnorm_reg  <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign vector_index     = vector_index_reg;
    assign score            = score_out_reg;
    assign zero_norm        = zero_norm_reg;
    assign best_match_index = best_match_index_out_reg;
    assign best_score       = best_score_out_reg;
    assign best_found       = best_found_out_reg;

    `CBMS_ASSERT_NXT(a_busy_after_accept, accept, !in_ready)
    `CBMS_ASSERT_IMP(a_start_when_idle, score_req.start, !score_rsp.busy)
    `CBMS_ASSERT_IMP(a_zero_norm_score, out_valid_reg && zero_norm_reg, score_out_reg == '0)
    `CBMS_ASSERT_IMP(a_best_positive, best_found_reg, best_score_reg > 0)
    `CBMS_ASSERT_IMP(a_no_best_clear, !best_found_reg, best_score_reg == '0 && best_match_index_reg == '0)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for cosine_best_match_search. Query and database words
// are queued per dim_in_use setting and sent through a valid/ready driver.
// A bit-exact predictor queues the expected result of every completed vector,
// and a monitor compares each result word against it. Both sides idle in
// random bursts. One phase holds off the receiver for a long stretch.
// ---------------------------------------------------------------------------
module tb_top;

    import cbms_pkg::*;

    localparam int   SETTLE_CYCLES = 200;
    localparam int   LONG_HOLD     = 1500;
    localparam int   CYCLE_LIMIT   = 500000;

    typedef struct {
        logic                     op;
        logic signed [ELEM_W-1:0] value;
    } search_word_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]     vector_index;
        logic signed [SCORE_W-1:0] score;
        logic                      zero_norm;
        logic [INDEX_BITS-1:0]     best_match_index;
        logic signed [SCORE_W-1:0] best_score;
        logic                      best_found;
    } match_result_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]          cfg_wr_data   = '0;
    logic                      in_valid      = 1'b0;
    logic                      in_ready;
    logic                      op            = OP_QUERY;
    logic signed [ELEM_W-1:0]  element_value = '0;
    logic                      out_valid;
    logic                      out_ready     = 1'b0;
    logic [INDEX_BITS-1:0]     vector_index;
    logic signed [SCORE_W-1:0] score;
    logic                      zero_norm;
    logic [INDEX_BITS-1:0]     best_match_index;
    logic signed [SCORE_W-1:0] best_score;
    logic                      best_found;

    search_word_t  pending_words[$];
    match_result_t expected_matches[$];
    match_result_t seen_match;
    match_result_t want_match;

    int  errors          = 0;
    int  words_queued    = 0;
    int  words_accepted  = 0;
    int  results_checked = 0;
    int  settings_done   = 0;
    int  cycle_count     = 0;
    int  gap_left        = 0;
    int  stall_left      = 0;
    int  hold_asked      = 0;
    int  hold_taken      = 0;
    bit  calm            = 1'b0;

    // predictor state
    logic [CFG_W-1:0]          dim_setting  = DIM_RESET;
    logic signed [ELEM_W-1:0]  query_copy [MAX_DIM];
    int unsigned               fill_at      = 0;
    int unsigned               elem_at      = 0;
    logic [NORM_W-1:0]         query_energy = '0;
    logic [NORM_W-1:0]         data_energy  = '0;
    logic [DOT_W-1:0]          dot_sum      = '0;
    logic [INDEX_BITS-1:0]     vectors_seen = '0;
    logic [INDEX_BITS-1:0]     leader_index = '0;
    logic signed [SCORE_W-1:0] leader_score = '0;
    logic                      leader_valid = 1'b0;

    // stimulus-side tracking, so no never-written query entry is read
    int unsigned               gen_dim  = 384;
    int unsigned               gen_fill = 0;
    int unsigned               gen_elem = 0;
    bit                        gen_written [MAX_DIM];
    logic signed [ELEM_W-1:0]  gen_query [MAX_DIM];

    cosine_best_match_search DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .element_value    (element_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .vector_index     (vector_index),
        .score            (score),
        .zero_norm        (zero_norm),
        .best_match_index (best_match_index),
        .best_score       (best_score),
        .best_found       (best_found)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_DIM)
            return MAX_DIM;
        return int'(setting);
    endfunction

    // largest k with k^2 * nq * nd <= dot^2 * 2^30, found by bisection
    function automatic logic signed [SCORE_W-1:0] cosine_score(
        input logic [DOT_W-1:0]  dot_bits,
        input logic [NORM_W-1:0] nq,
        input logic [NORM_W-1:0] nd
    );
        logic [DOT_W-1:0] mag;
        logic [127:0]     prod;
        logic [127:0]     rhs;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        mag  = dot_bits[DOT_W-1] ? (~dot_bits + 1'b1) : dot_bits;
        prod = 128'(nq) * 128'(nd);
        rhs  = (128'(mag) * 128'(mag)) << FRAC_W;
        lo   = 0;
        hi   = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (prod * (128'(mid) * 128'(mid)) <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (dot_bits[DOT_W-1])
            return SCORE_W'(-int'(lo));
        return (lo > 32767) ? 16'sh7fff : SCORE_W'(lo);
    endfunction

    task automatic step_search(input logic word_op, input logic signed [ELEM_W-1:0] val);
        int unsigned               span;
        int unsigned               pos;
        logic [NORM_W-1:0]         sq;
        logic                      no_norm;
        logic signed [SCORE_W-1:0] s;
        span = eff_dim(dim_setting);
        sq   = NORM_W'(int'(val) * int'(val));
        if (word_op == OP_QUERY)
        begin
            pos = (fill_at >= span) ? 0 : fill_at;
            if (pos == 0)
            begin
                // query element 0 restarts the search
                query_energy = '0;
                elem_at      = 0;
                dot_sum      = '0;
                data_energy  = '0;
                vectors_seen = '0;
                leader_score = '0;
                leader_index = '0;
                leader_valid = 1'b0;
            end
            query_copy[pos] = val;
            query_energy    = query_energy + sq;
            fill_at         = (pos + 1 >= span) ? 0 : pos + 1;
        end
        else
        begin
            pos         = (elem_at >= span) ? 0 : elem_at;
            dot_sum     = dot_sum + DOT_W'(int'(query_copy[pos]) * int'(val));
            data_energy = data_energy + sq;
            if (pos + 1 < span)
                elem_at = pos + 1;
            else
            begin
                no_norm = (query_energy == 0) || (data_energy == 0);
                s = no_norm ? '0 : cosine_score(dot_sum, query_energy, data_energy);
                if (!no_norm && s > leader_score)
                begin
                    leader_score = s;
                    leader_index = vectors_seen;
                    leader_valid = 1'b1;
                end
                expected_matches.push_back('{vectors_seen, s, no_norm,
                                             leader_index, leader_score, leader_valid});
                vectors_seen = vectors_seen + 1'b1;
                elem_at      = 0;
                dot_sum      = '0;
                data_energy  = '0;
            end
        end
    endtask

    task automatic note_failure(input string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    function automatic logic signed [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return ELEM_W'(int'($urandom_range(0, 8)) - 4);
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic push_word(input logic word_op, input logic signed [ELEM_W-1:0] val);
        int unsigned pos;
        if (word_op == OP_QUERY)
        begin
            pos              = (gen_fill >= gen_dim) ? 0 : gen_fill;
            gen_written[pos] = 1'b1;
            gen_query[pos]   = val;
            gen_fill         = (pos + 1 >= gen_dim) ? 0 : pos + 1;
        end
        else
        begin
            pos      = (gen_elem >= gen_dim) ? 0 : gen_elem;
            gen_elem = (pos + 1 < gen_dim) ? pos + 1 : 0;
        end
        pending_words.push_back('{word_op, val});
        words_queued++;
    endtask

    function automatic bit query_ready();
        for (int i = 0; i < gen_dim; i++)
            if (!gen_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // finishes the current query, or sends a whole one from element 0
    task automatic send_query();
        bit blank;
        blank = ($urandom_range(0, 11) == 0);
        do
            push_word(OP_QUERY, blank ? 16'sh0 : rand_element());
        while (gen_fill != 0);
    endtask

    // finishes the current database vector; kind picks how it relates to the query
    task automatic send_vector(input int unsigned kind);
        int unsigned              pos;
        int                       nudged;
        logic signed [ELEM_W-1:0] q;
        logic signed [ELEM_W-1:0] v;
        do
        begin
            pos = (gen_elem >= gen_dim) ? 0 : gen_elem;
            q   = gen_query[pos];
            case (kind)
                1: v = q;
                2: v = (q == -32768) ? 16'sh7fff : -q;
                3: v = '0;
                4: v = q >>> 1;
                5, 6:
                begin
                    nudged = int'(q) + int'($urandom_range(0, 64)) - 32;
                    if (nudged > 32767)
                        nudged = 32767;
                    if (nudged < -32768)
                        nudged = -32768;
                    v = ELEM_W'(nudged);
                end
                default: v = rand_element();
            endcase
            push_word(OP_DATA, v);
        end
        while (gen_elem != 0);
    endtask

    task automatic send_noise(input int unsigned count);
        logic        word_op;
        int unsigned pos;
        repeat (count)
        begin
            word_op = ($urandom_range(0, 1) == 1) ? OP_DATA : OP_QUERY;
            pos     = (gen_elem >= gen_dim) ? 0 : gen_elem;
            if (!gen_written[pos])
                word_op = OP_QUERY;
            push_word(word_op, rand_element());
        end
    endtask

    // wait until every word is taken and every result is back, then let the engine go quiet
    task automatic settle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_matches.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_dim(input logic [CFG_W-1:0] setting);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        dim_setting  = setting;
        gen_dim      = eff_dim(setting);
        settings_done++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] setting, input int count, input bit hold);
        int first;
        settle();
        write_dim(setting);
        first = words_queued;
        if (hold)
            hold_asked++;
        while (words_queued - first < count)
        begin
            if (!query_ready())
                send_query();
            else
                case ($urandom_range(0, 9))
                    0: send_noise($urandom_range(1, 4));
                    1: send_query();
                    default: send_vector($urandom_range(0, 7));
                endcase
        end
        // leave a partial query or vector behind for the next setting
        send_noise($urandom_range(1, 6));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                step_search(op, element_value);
                words_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_valid      <= 1'b1;
                    op            <= pending_words[0].op;
                    element_value <= pending_words[0].value;
                    void'(pending_words.pop_front());
                    if (!calm && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 15);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_match = '{vector_index, score, zero_norm,
                               best_match_index, best_score, best_found};
                results_checked++;
                if (expected_matches.size() == 0)
                    note_failure($sformatf("result word with nothing expected, vector_index=%0d",
                                           vector_index));
                else
                begin
                    want_match = expected_matches.pop_front();
                    if (seen_match !== want_match)
                        note_failure($sformatf({"mismatch exp idx=%0d score=%0d zero=%0b ",
                            "best=%0d/%0d found=%0b | got idx=%0d score=%0d zero=%0b ",
                            "best=%0d/%0d found=%0b"},
                            want_match.vector_index, want_match.score, want_match.zero_norm,
                            want_match.best_match_index, want_match.best_score,
                            want_match.best_found,
                            seen_match.vector_index, seen_match.score, seen_match.zero_norm,
                            seen_match.best_match_index, seen_match.best_score,
                            seen_match.best_found));
                end
            end
            if (hold_asked != hold_taken)
            begin
                hold_taken = hold_asked;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 15);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_matches.size());
            $display("** cosine_best_match_search: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at two elements per vector
        write_dim(10'd2);
        push_word(OP_QUERY, 16'sh8000);
        push_word(OP_QUERY, 16'sh7fff);
        push_word(OP_DATA, 16'sh8000);      // same as query: saturates high
        push_word(OP_DATA, 16'sh7fff);
        push_word(OP_DATA, 16'sh7fff);      // near opposite: negative score
        push_word(OP_DATA, 16'sh8000);
        push_word(OP_DATA, 16'sh0);         // zero vector norm
        push_word(OP_DATA, 16'sh0);
        push_word(OP_DATA, 16'sh8000);      // tie keeps the earlier best
        push_word(OP_DATA, 16'sh7fff);
        push_word(OP_DATA, 16'sh1);
        push_word(OP_DATA, 16'sh0);
        push_word(OP_DATA, 16'sh5);         // partial vector, dropped by the restart
        push_word(OP_QUERY, 16'sh4000);
        push_word(OP_QUERY, 16'sh0);
        push_word(OP_DATA, -16'sh4000);     // exactly opposite: most negative score
        push_word(OP_DATA, 16'sh0);
        push_word(OP_QUERY, 16'sh0);        // zero query norm
        push_word(OP_QUERY, 16'sh0);
        push_word(OP_DATA, 16'sh64);
        push_word(OP_DATA, 16'shc8);
        push_word(OP_QUERY, 16'sh3);        // partial query: norm covers element 0 only
        push_word(OP_DATA, 16'sh3);
        push_word(OP_DATA, 16'sh7);

        run_phase(10'd16, 100, 1'b0);
        run_phase(10'd3, 90, 1'b0);
        run_phase(10'd0, 80, 1'b1);         // one-word vectors against a long receiver hold

        // setting above the maximum, a few words left open for the next setting
        settle();
        write_dim(10'd1023);
        send_noise($urandom_range(4, 8));

        run_phase(10'd7, 100, 1'b0);
        run_phase(10'd1, 60, 1'b0);
        run_phase(10'd40, 110, 1'b0);
        calm = 1'b1;
        run_phase(10'd4, 100, 1'b0);
        settle();

        if (expected_matches.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_matches.size()));
        $display("covered %0d words and %0d scored vectors over %0d dim_in_use settings",
                 words_accepted, results_checked, settings_done);
        $display("settings spanned 0 up to 1023 (capped at %0d); %0d mismatches",
                 MAX_DIM, errors);
        if (errors == 0)
            $display("** cosine_best_match_search: PASSED **");
        else
            $display("** cosine_best_match_search: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/cbms_pkg.sv
sv/cbms_score.sv
sv/cosine_best_match_search.sv
tb/tb_top.sv
